@@ src/ata_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_pkg
// Shared types and constants of the ATA PIO LBA28 task file target.
// ----------------------------------------------------------------------------
package ata_pkg;

  localparam int WORD_IDX_W = 8;
  localparam int WORDS_PER_SECTOR = 256;
  localparam int SEC_CNT_W = 9;
  localparam int LBA28_W = 28;

  localparam logic [2:0] PORT_DATA  = 3'd0;
  localparam logic [2:0] PORT_ERROR = 3'd1;
  localparam logic [2:0] PORT_COUNT = 3'd2;
  localparam logic [2:0] PORT_LBA0  = 3'd3;
  localparam logic [2:0] PORT_LBA1  = 3'd4;
  localparam logic [2:0] PORT_LBA2  = 3'd5;
  localparam logic [2:0] PORT_DRIVE = 3'd6;
  localparam logic [2:0] PORT_CMD   = 3'd7;

  localparam logic [7:0] CMD_READ  = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h30;
  localparam logic [7:0] CMD_FLUSH = 8'hE7;

  localparam logic [7:0]  DRIVE_RESET = 8'hE0;
  localparam logic [7:0]  COUNT_RESET = 8'h01;
  localparam logic [15:0] ERR_ABORT   = 16'h0004;

  localparam int STATUS_READY_BIT = 6;
  localparam int STATUS_DRQ_BIT   = 3;
  localparam int STATUS_ERR_BIT   = 0;

  typedef struct packed {
    logic clr;       // store sweep step
    logic take;      // input beat accepted
    logic load_reg;  // load output from register result
    logic load_mem;  // load output from store read data
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mem_read;
  } dp_status_t;

endpackage

@@ src/ata_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_store
// Sector word store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ata_store #(
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [15:0]       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [15:0]       rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/ata_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_dp
// Task file registers, transfer counters, sector store and output register.
// ----------------------------------------------------------------------------
module ata_dp #(
  parameter int SECTORS = 64,
  parameter int LBA_W   = 6,
  parameter int ADDR_W  = 14,
  parameter int DEPTH   = 16384
) (
  input  logic                clk,
  input  logic                rst,
  input  ata_pkg::ctrl_cmd_t  cmd,
  output ata_pkg::dp_status_t status,
  input  logic [23:0]         in_data,
  output logic [15:0]         out_data
);

  logic        action;
  logic [2:0]  port_offset;
  logic [15:0] write_data;
  logic [7:0]  lo;

  logic [7:0]  count_reg;
  logic [7:0]  lba0;
  logic [7:0]  lba1;
  logic [7:0]  lba2;
  logic [7:0]  drive_head_reg;
  logic        drq_flag;
  logic        err_flag;
  logic        writing_dir;
  logic [ata_pkg::WORD_IDX_W-1:0] word_index;
  logic [ata_pkg::SEC_CNT_W-1:0]  sectors_left;
  logic [LBA_W-1:0]               current_lba;
  logic [ADDR_W-1:0]              clr_addr;

  logic [ata_pkg::LBA28_W-1:0]    req_lba;
  logic [ata_pkg::SEC_CNT_W-1:0]  req_cnt;
  logic [ata_pkg::LBA28_W:0]      req_end;
  logic                           req_bad;
  logic [ata_pkg::SEC_CNT_W-1:0]  sectors_left_next;

  logic              data_wr;
  logic              data_rd;
  logic              step;
  logic              store_we;
  logic [ADDR_W-1:0] store_addr;
  logic [ADDR_W-1:0] store_waddr;
  logic [15:0]       store_wdata;
  logic [15:0]       store_rdata;
  logic [15:0]       reg_result;

  assign action      = in_data[0];
  assign port_offset = in_data[3:1];
  assign write_data  = in_data[19:4];
  assign lo          = write_data[7:0];

  assign store_addr = ADDR_W'({current_lba, word_index});

  assign data_wr = cmd.take && action && (port_offset == ata_pkg::PORT_DATA)
                   && drq_flag && writing_dir;
  assign data_rd = !action && (port_offset == ata_pkg::PORT_DATA)
                   && drq_flag && !writing_dir;
  assign step    = data_wr || (cmd.take && data_rd);

  assign status.mem_read   = data_rd;
  assign status.clear_last = (clr_addr == ADDR_W'(DEPTH - 1));

  assign req_lba = {drive_head_reg[3:0], lba2, lba1, lba0};
  assign req_cnt = (count_reg == 8'd0) ? ata_pkg::SEC_CNT_W'(256)
                                       : ata_pkg::SEC_CNT_W'(count_reg);
  assign req_end = {1'b0, req_lba} + (ata_pkg::LBA28_W + 1)'(req_cnt);
  assign req_bad = req_end > (ata_pkg::LBA28_W + 1)'(SECTORS);

  assign sectors_left_next = (sectors_left == '0) ? '0
                             : sectors_left - ata_pkg::SEC_CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr && !status.clear_last) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg      <= ata_pkg::COUNT_RESET;
      lba0           <= '0;
      lba1           <= '0;
      lba2           <= '0;
      drive_head_reg <= ata_pkg::DRIVE_RESET;
      drq_flag       <= 1'b0;
      err_flag       <= 1'b0;
      writing_dir    <= 1'b0;
      word_index     <= '0;
      sectors_left   <= '0;
      current_lba    <= '0;
    end else if (step) begin
      word_index <= word_index + ata_pkg::WORD_IDX_W'(1);
      if (word_index == ata_pkg::WORD_IDX_W'(ata_pkg::WORDS_PER_SECTOR - 1)) begin
        current_lba  <= current_lba + LBA_W'(1);
        sectors_left <= sectors_left_next;
        if (sectors_left_next == '0) begin
          drq_flag <= 1'b0;
        end
      end
    end else if (cmd.take && action) begin
      case (port_offset)
        ata_pkg::PORT_COUNT: count_reg      <= lo;
        ata_pkg::PORT_LBA0:  lba0           <= lo;
        ata_pkg::PORT_LBA1:  lba1           <= lo;
        ata_pkg::PORT_LBA2:  lba2           <= lo;
        ata_pkg::PORT_DRIVE: drive_head_reg <= lo;
        ata_pkg::PORT_CMD: begin
          drq_flag <= 1'b0;
          err_flag <= 1'b0;
          if (lo == ata_pkg::CMD_READ || lo == ata_pkg::CMD_WRITE) begin
            if (req_bad) begin
              err_flag <= 1'b1;
            end else begin
              current_lba  <= req_lba[LBA_W-1:0];
              sectors_left <= req_cnt;
              word_index   <= '0;
              writing_dir  <= (lo == ata_pkg::CMD_WRITE);
              drq_flag     <= 1'b1;
            end
          end else if (lo != ata_pkg::CMD_FLUSH) begin
            err_flag <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    reg_result = '0;
    if (!action) begin
      case (port_offset)
        ata_pkg::PORT_ERROR: reg_result = err_flag ? ata_pkg::ERR_ABORT : '0;
        ata_pkg::PORT_COUNT: reg_result = {8'd0, count_reg};
        ata_pkg::PORT_LBA0:  reg_result = {8'd0, lba0};
        ata_pkg::PORT_LBA1:  reg_result = {8'd0, lba1};
        ata_pkg::PORT_LBA2:  reg_result = {8'd0, lba2};
        ata_pkg::PORT_DRIVE: reg_result = {8'd0, drive_head_reg};
        ata_pkg::PORT_CMD: begin
          reg_result[ata_pkg::STATUS_READY_BIT] = 1'b1;
          reg_result[ata_pkg::STATUS_DRQ_BIT]   = drq_flag;
          reg_result[ata_pkg::STATUS_ERR_BIT]   = err_flag;
        end
        default: reg_result = '0;
      endcase
    end
  end

  assign store_we    = cmd.clr || data_wr;
  assign store_waddr = cmd.clr ? clr_addr : store_addr;
  assign store_wdata = cmd.clr ? 16'd0 : write_data;

  ata_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .re    (cmd.take && data_rd),
    .raddr (store_addr),
    .rdata (store_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_mem) begin
      out_data <= store_rdata;
    end else if (cmd.load_reg) begin
      out_data <= reg_result;
    end
  end

endmodule

@@ src/ata_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_ctrl
// Sequencer: store sweep after reset, beat acceptance, output valid.
// ----------------------------------------------------------------------------
module ata_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  ata_pkg::dp_status_t status,
  output ata_pkg::ctrl_cmd_t  cmd,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready
);

  typedef enum logic [2:0] {
    S_CLEAR  = 3'b001,
    S_IDLE   = 3'b010,
    S_RDWAIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready     = (state == S_IDLE) && (!out_valid || out_ready);
  assign cmd.clr      = (state == S_CLEAR);
  assign cmd.take     = in_valid && in_ready;
  assign cmd.load_reg = cmd.take && !status.mem_read;
  assign cmd.load_mem = (state == S_RDWAIT);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (status.clear_last) state_next = S_IDLE;
      S_IDLE:   if (cmd.take && status.mem_read) state_next = S_RDWAIT;
      S_RDWAIT: state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_reg || cmd.load_mem) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ src/ata_pio_lba28_disk_target.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_pio_lba28_disk_target
// Device side of an ATA PIO LBA28 task file with a built-in sector store.
// ----------------------------------------------------------------------------
// After reset the block sweeps the store to zero, one word a cycle, and holds
// s_tready low meanwhile. Then a register access is answered from the task
// file registers, and a data-port read during a read transfer first reads the
// registered read port of the store in a wait state before its word is loaded.
// A result beat waits in an output register; the next access is taken once the
// read wait is over and that register is free or drained in the same cycle.
module ata_pio_lba28_disk_target #(
  parameter int SECTORS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // action[0], port_offset[3:1], write_data[19:4], zero[23:20]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // read_data[15:0]
);

  localparam int LBA_W  = (SECTORS > 1) ? $clog2(SECTORS) : 1;
  localparam int ADDR_W = LBA_W + ata_pkg::WORD_IDX_W;
  localparam int DEPTH  = SECTORS * ata_pkg::WORDS_PER_SECTOR;

  ata_pkg::ctrl_cmd_t  cmd;
  ata_pkg::dp_status_t status;

  ata_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .cmd       (cmd),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  ata_dp #(
    .SECTORS (SECTORS),
    .LBA_W   (LBA_W),
    .ADDR_W  (ADDR_W),
    .DEPTH   (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (s_tdata),
    .out_data (m_tdata)
  );

  a_no_take_in_clear : assert property (@(posedge clk) disable iff (rst)
    cmd.clr |-> !s_tready)
    else $error("beat accepted during store sweep");

  a_mem_after_take : assert property (@(posedge clk) disable iff (rst)
    cmd.load_mem |-> $past(cmd.take) && $past(status.mem_read))
    else $error("store data loaded without a data read");

  a_out_free_on_mem : assert property (@(posedge clk) disable iff (rst)
    cmd.load_mem |-> !m_tvalid)
    else $error("store data would overwrite a pending result");

endmodule

@@ tb/tb_ata_pio_lba28_disk_target.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ata_pio_lba28_disk_target
// Self-checking bench for the ATA PIO LBA28 task file target. A behavioral
// copy of the task file and sector store predicts every read beat. Directed
// tests cover register limits, each command and the abort, direction and
// range rules. A two-sector write runs across a sector boundary and the second
// sector is then read back whole. Random register setups, commands and data
// bursts follow under four handshake gap patterns.
// ----------------------------------------------------------------------------
module tb_ata_pio_lba28_disk_target;

  localparam int N_SECTORS   = 64;
  localparam int STORE_WORDS = N_SECTORS * ata_pkg::WORDS_PER_SECTOR;
  // store sweep after reset plus generous margin
  localparam int STALL_LIMIT = 4 * STORE_WORDS;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;
  localparam logic [7:0] CMD_IDENTIFY = 8'hEC;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  // task file shadow
  logic [7:0]  dev_count;
  logic [7:0]  dev_lba [0:2];
  logic [7:0]  dev_drive;
  logic        dev_drq;
  logic        dev_err;
  logic        dev_wr_dir;
  logic [7:0]  xfer_word;
  logic [8:0]  xfer_left;
  logic [27:0] xfer_lba;
  logic [15:0] sector_mem [0:STORE_WORDS-1];
  logic        beat_ignored;

  logic [15:0] expected_reads[$];
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int fail_count = 0;
  int beats_sent = 0;
  int useful_beats = 0;
  int results_checked = 0;
  int sectors_done = 0;
  int quiet_cycles = 0;
  logic [27:0] last_write_lba = '0;
  logic        have_written = 1'b0;

  ata_pio_lba28_disk_target #(
    .SECTORS(N_SECTORS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int take_word_addr();
    int a;
    begin
      a = int'(xfer_lba) * ata_pkg::WORDS_PER_SECTOR + int'(xfer_word);
      if (xfer_word == 8'hFF) begin
        xfer_word = '0;
        xfer_lba = xfer_lba + 28'd1;
        if (xfer_left != 0) xfer_left = xfer_left - 9'd1;
        if (xfer_left == 0) dev_drq = 1'b0;
        sectors_done++;
      end else begin
        xfer_word = xfer_word + 8'd1;
      end
      return a;
    end
  endfunction

  function automatic logic [15:0] task_file_access(input logic act, input logic [2:0] port,
                                                   input logic [15:0] wd);
    logic [15:0] rdata;
    logic [31:0] start_lba;
    int nsec;
    int a;
    begin
      rdata = '0;
      beat_ignored = 1'b0;
      if (act == ACT_WRITE) begin
        case (port)
          ata_pkg::PORT_DATA: begin
            if (dev_drq && dev_wr_dir) begin
              a = take_word_addr();
              if (a < STORE_WORDS) sector_mem[a] = wd;
            end else begin
              beat_ignored = 1'b1;
            end
          end
          ata_pkg::PORT_COUNT: dev_count = wd[7:0];
          ata_pkg::PORT_LBA0:  dev_lba[0] = wd[7:0];
          ata_pkg::PORT_LBA1:  dev_lba[1] = wd[7:0];
          ata_pkg::PORT_LBA2:  dev_lba[2] = wd[7:0];
          ata_pkg::PORT_DRIVE: dev_drive = wd[7:0];
          ata_pkg::PORT_CMD: begin
            dev_drq = 1'b0;
            dev_err = 1'b0;
            if (wd[7:0] == ata_pkg::CMD_READ || wd[7:0] == ata_pkg::CMD_WRITE) begin
              start_lba = {4'd0, dev_drive[3:0], dev_lba[2], dev_lba[1], dev_lba[0]};
              nsec = (dev_count == 0) ? 256 : int'(dev_count);
              if (start_lba + 32'(nsec) > 32'(N_SECTORS)) begin
                dev_err = 1'b1;
              end else begin
                xfer_lba = start_lba[27:0];
                xfer_left = 9'(nsec);
                xfer_word = '0;
                dev_wr_dir = (wd[7:0] == ata_pkg::CMD_WRITE);
                dev_drq = 1'b1;
              end
            end else if (wd[7:0] != ata_pkg::CMD_FLUSH) begin
              dev_err = 1'b1;
            end
          end
          default: beat_ignored = 1'b1;
        endcase
      end else begin
        case (port)
          ata_pkg::PORT_DATA: begin
            if (dev_drq && !dev_wr_dir) begin
              a = take_word_addr();
              if (a < STORE_WORDS) rdata = sector_mem[a];
            end else begin
              beat_ignored = 1'b1;
            end
          end
          ata_pkg::PORT_ERROR: rdata = dev_err ? ata_pkg::ERR_ABORT : 16'h0000;
          ata_pkg::PORT_COUNT: rdata = {8'h00, dev_count};
          ata_pkg::PORT_LBA0:  rdata = {8'h00, dev_lba[0]};
          ata_pkg::PORT_LBA1:  rdata = {8'h00, dev_lba[1]};
          ata_pkg::PORT_LBA2:  rdata = {8'h00, dev_lba[2]};
          ata_pkg::PORT_DRIVE: rdata = {8'h00, dev_drive};
          default: begin
            rdata[ata_pkg::STATUS_READY_BIT] = 1'b1;
            rdata[ata_pkg::STATUS_DRQ_BIT] = dev_drq;
            rdata[ata_pkg::STATUS_ERR_BIT] = dev_err;
          end
        endcase
      end
      return rdata;
    end
  endfunction

  task automatic send_beat(input logic act, input logic [2:0] port, input logic [15:0] wd);
    begin
      @(negedge clk);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= {4'h0, wd, port, act};
      do @(posedge clk); while (!s_tready);
      expected_reads.push_back(task_file_access(act, port, wd));
      beats_sent++;
      if (!beat_ignored) useful_beats++;
    end
  endtask

  task automatic put_reg(input logic [2:0] port, input logic [7:0] val);
    logic [15:0] wd;
    begin
      wd = 16'($urandom_range(0, 65535));
      wd[7:0] = val;
      send_beat(ACT_WRITE, port, wd);
    end
  endtask

  task automatic wait_results_drained();
    begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      while (expected_reads.size() != 0) @(posedge clk);
    end
  endtask

  task automatic test_reset_state();
    logic [2:0] p;
    begin
      for (int i = 0; i < 8; i++) begin
        p = 3'(i);
        send_beat(ACT_READ, p, 16'h0000);
      end
    end
  endtask

  task automatic test_register_limits();
    begin
      send_beat(ACT_WRITE, ata_pkg::PORT_COUNT, 16'hFFFF);
      send_beat(ACT_READ, ata_pkg::PORT_COUNT, 16'h0000);
      send_beat(ACT_WRITE, ata_pkg::PORT_LBA0, 16'h5AFF);
      send_beat(ACT_WRITE, ata_pkg::PORT_LBA1, 16'hFFFF);
      send_beat(ACT_WRITE, ata_pkg::PORT_LBA2, 16'hFFFF);
      send_beat(ACT_READ, ata_pkg::PORT_LBA0, 16'hFFFF);
      send_beat(ACT_WRITE, ata_pkg::PORT_DRIVE, 16'hFFFF);
      send_beat(ACT_READ, ata_pkg::PORT_DRIVE, 16'h0000);
      send_beat(ACT_WRITE, ata_pkg::PORT_ERROR, 16'hFFFF);
      send_beat(ACT_READ, ata_pkg::PORT_ERROR, 16'h0000);
    end
  endtask

  task automatic test_commands();
    begin
      // out of range with every address bit set
      send_beat(ACT_WRITE, ata_pkg::PORT_CMD, {8'hFF, ata_pkg::CMD_WRITE});
      send_beat(ACT_READ, ata_pkg::PORT_ERROR, 16'h0000);
      send_beat(ACT_WRITE, ata_pkg::PORT_CMD, {8'h00, CMD_IDENTIFY});
      send_beat(ACT_WRITE, ata_pkg::PORT_CMD, {8'h00, ata_pkg::CMD_FLUSH});
      send_beat(ACT_READ, ata_pkg::PORT_CMD, 16'h0000);
      // count zero means 256 sectors, past the store
      put_reg(ata_pkg::PORT_COUNT, 8'h00);
      put_reg(ata_pkg::PORT_LBA1, 8'h00);
      put_reg(ata_pkg::PORT_LBA2, 8'h00);
      put_reg(ata_pkg::PORT_DRIVE, ata_pkg::DRIVE_RESET);
      put_reg(ata_pkg::PORT_LBA0, 8'h00);
      send_beat(ACT_WRITE, ata_pkg::PORT_CMD, {8'h00, ata_pkg::CMD_READ});
      send_beat(ACT_READ, ata_pkg::PORT_CMD, 16'h0000);
      // last sector: write a word, then read it back under a new read command
      put_reg(ata_pkg::PORT_COUNT, 8'h01);
      put_reg(ata_pkg::PORT_LBA0, 8'(N_SECTORS - 1));
      send_beat(ACT_WRITE, ata_pkg::PORT_CMD, {8'h00, ata_pkg::CMD_WRITE});
      send_beat(ACT_WRITE, ata_pkg::PORT_DATA, 16'hFFFF);
      send_beat(ACT_READ, ata_pkg::PORT_DATA, 16'h0000);
      send_beat(ACT_WRITE, ata_pkg::PORT_CMD, {8'h00, ata_pkg::CMD_READ});
      send_beat(ACT_READ, ata_pkg::PORT_DATA, 16'h0000);
      send_beat(ACT_WRITE, ata_pkg::PORT_DATA, 16'h1234);
      send_beat(ACT_READ, ata_pkg::PORT_CMD, 16'h0000);
    end
  endtask

  task automatic test_sector_crossing();
    begin
      // two-sector write, stop just past the boundary
      put_reg(ata_pkg::PORT_COUNT, 8'd2);
      put_reg(ata_pkg::PORT_LBA0, 8'd10);
      put_reg(ata_pkg::PORT_LBA1, 8'h00);
      put_reg(ata_pkg::PORT_LBA2, 8'h00);
      put_reg(ata_pkg::PORT_DRIVE, ata_pkg::DRIVE_RESET);
      send_beat(ACT_WRITE, ata_pkg::PORT_CMD, {8'h00, ata_pkg::CMD_WRITE});
      repeat (ata_pkg::WORDS_PER_SECTOR + 2)
        send_beat(ACT_WRITE, ata_pkg::PORT_DATA, 16'($urandom_range(0, 65535)));
      send_beat(ACT_READ, ata_pkg::PORT_CMD, 16'h0000);
      // read the second sector whole, DRQ drops after its last word
      put_reg(ata_pkg::PORT_COUNT, 8'd1);
      put_reg(ata_pkg::PORT_LBA0, 8'd11);
      send_beat(ACT_WRITE, ata_pkg::PORT_CMD, {8'h00, ata_pkg::CMD_READ});
      repeat (ata_pkg::WORDS_PER_SECTOR)
        send_beat(ACT_READ, ata_pkg::PORT_DATA, 16'h0000);
      send_beat(ACT_READ, ata_pkg::PORT_CMD, 16'h0000);
      send_beat(ACT_READ, ata_pkg::PORT_DATA, 16'h0000);
    end
  endtask

  task automatic test_random_transfers(input int target, input int send_pct,
                                       input int recv_pct);
    int start_beats;
    int nsec;
    int words;
    int pick;
    int i;
    logic [27:0] lba;
    logic [7:0] cmd;
    logic [7:0] cnt;
    logic act;
    begin
      sender_idle_pct = send_pct;
      receiver_stall_pct = recv_pct;
      start_beats = beats_sent;
      while (beats_sent - start_beats < target) begin
        if ($urandom_range(0, 99) < 80) begin
          pick = $urandom_range(0, 99);
          if (pick < 45) cmd = ata_pkg::CMD_READ;
          else if (pick < 90) cmd = ata_pkg::CMD_WRITE;
          else if (pick < 95) cmd = ata_pkg::CMD_FLUSH;
          else begin
            do cmd = 8'($urandom_range(0, 255));
            while (cmd == ata_pkg::CMD_READ || cmd == ata_pkg::CMD_WRITE ||
                   cmd == ata_pkg::CMD_FLUSH);
          end
          pick = $urandom_range(0, 99);
          if (pick < 70) cnt = 8'd1;
          else if (pick < 85) cnt = 8'($urandom_range(2, 4));
          else if (pick < 95) cnt = 8'($urandom_range(0, 255));
          else cnt = 8'd0;
          nsec = (cnt == 0) ? 256 : int'(cnt);
          if ($urandom_range(0, 99) < 80 && nsec <= N_SECTORS) begin
            if (cmd == ata_pkg::CMD_READ && have_written && $urandom_range(0, 1) == 1)
              lba = last_write_lba;
            else
              lba = 28'($urandom_range(0, N_SECTORS - nsec));
          end else begin
            lba = 28'($urandom);
          end
          put_reg(ata_pkg::PORT_COUNT, cnt);
          put_reg(ata_pkg::PORT_LBA0, lba[7:0]);
          put_reg(ata_pkg::PORT_LBA1, lba[15:8]);
          put_reg(ata_pkg::PORT_LBA2, lba[23:16]);
          put_reg(ata_pkg::PORT_DRIVE, {4'($urandom_range(0, 15)), lba[27:24]});
          if ($urandom_range(0, 3) == 0)
            send_beat(ACT_READ, 3'($urandom_range(1, 7)), 16'($urandom_range(0, 65535)));
          put_reg(ata_pkg::PORT_CMD, cmd);
          if (cmd == ata_pkg::CMD_WRITE) begin
            last_write_lba = lba;
            have_written = 1'b1;
          end
          words = $urandom_range(0, 24);
          i = 0;
          while (i < words) begin
            pick = $urandom_range(0, 99);
            act = (cmd == ata_pkg::CMD_WRITE) ? ACT_WRITE : ACT_READ;
            if (pick < 5) begin
              send_beat(ACT_READ, ata_pkg::PORT_CMD, 16'($urandom_range(0, 65535)));
            end else begin
              if (pick >= 95) act = ~act;
              send_beat(act, ata_pkg::PORT_DATA, 16'($urandom_range(0, 65535)));
            end
            i++;
          end
          send_beat(ACT_READ, ata_pkg::PORT_CMD, 16'($urandom_range(0, 65535)));
          if ($urandom_range(0, 1) == 1)
            send_beat(ACT_READ, ata_pkg::PORT_ERROR, 16'($urandom_range(0, 65535)));
        end else begin
          repeat ($urandom_range(1, 6))
            send_beat(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      16'($urandom_range(0, 65535)));
        end
      end
      wait_results_drained();
    end
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reads.size() == 0) begin
        $error("read_data: no beat expected, got %h", m_tdata);
        fail_count++;
      end else begin
        if (m_tdata !== expected_reads[0]) begin
          $error("read_data: expected %h, got %h", expected_reads[0], m_tdata);
          fail_count++;
        end
        void'(expected_reads.pop_front());
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    dev_count = ata_pkg::COUNT_RESET;
    dev_lba[0] = '0;
    dev_lba[1] = '0;
    dev_lba[2] = '0;
    dev_drive = ata_pkg::DRIVE_RESET;
    dev_drq = 1'b0;
    dev_err = 1'b0;
    dev_wr_dir = 1'b0;
    xfer_word = '0;
    xfer_left = '0;
    xfer_lba = '0;
    for (int a = 0; a < STORE_WORDS; a++) sector_mem[a] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_register_limits();
    test_commands();
    wait_results_drained();
    test_sector_crossing();
    wait_results_drained();

    test_random_transfers(60, 0, 0);
    test_random_transfers(60, 49, 0);
    test_random_transfers(60, 0, 49);
    test_random_transfers(60, 14, 14);

    repeat (10) @(posedge clk);
    $display("covered %0d bus beats (%0d with effect), %0d results checked, %0d sectors moved",
             beats_sent, useful_beats, results_checked, sectors_done);
    $display("across free-running, sender-gap, receiver-stall and mixed handshake phases");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
